// ----- rtl/entry_pool_with_timed_queue_core_macros.svh -----
// Assertion macros used by the checker in epq_checker.sv.
// No dependencies.
`ifndef ENTRY_POOL_WITH_TIMED_QUEUE_CORE_MACROS_SVH
`define ENTRY_POOL_WITH_TIMED_QUEUE_CORE_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define EPQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define EPQ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/epq_pkg.sv -----
// Package for the entry pool with timed queue: sizes, commands, codes.
// No dependencies.
package epq_pkg;
   localparam int ENTRIES   = 128;
   localparam int IDX_BITS  = $clog2(ENTRIES);
   localparam int LVL_BITS  = $clog2(ENTRIES + 1);
   localparam int TIME_BITS = 32;

   localparam logic [2:0] CMD_ALLOC  = 3'd0;
   localparam logic [2:0] CMD_FREE   = 3'd1;
   localparam logic [2:0] CMD_QUEUE  = 3'd2;
   localparam logic [2:0] CMD_REMOVE = 3'd3;
   localparam logic [2:0] CMD_PEEK   = 3'd4;
   localparam logic [2:0] CMD_RESET  = 3'd5;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_BAD   = 2'd2;

   localparam logic [1:0] ES_FREE  = 2'd0;
   localparam logic [1:0] ES_ALLOC = 2'd1;
   localparam logic [1:0] ES_PEND  = 2'd2;

   typedef struct packed {
      logic [2:0]  command;
      logic [6:0]  entry;
      logic [31:0] begin_time;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [6:0]  result_entry;
      logic [31:0] head_begin;
      logic        pending_nonempty;
      logic [7:0]  free_count;
   } rsp_type;
endpackage

// ----- rtl/epq_req_if.sv -----
// Valid/ready channel interfaces for command and result words.
// Depends on epq_pkg.
interface epq_req_if;
   import epq_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface epq_rsp_if;
   import epq_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/entry_pool_with_timed_queue_core.sv -----
// Entry pool with free FIFO and start-time sorted pending list, top level.
// Depends on epq_pkg and the channel interfaces in epq_req_if.sv.
//
// Usage: one command word enters on req (valid/ready); exactly one result
// word leaves on rsp. Commands: allocate, free, queue, remove, peek, reset.
// One command is in flight at a time. Remove, and free of a pending
// entry, scan every pending order slot. Queue reads the order slot and
// start time of each earlier slot, then moves the later slots up. A reset
// command, and the reset input, run a clearing pass that rewrites the free
// FIFO memory with the index order, one entry a cycle, while req is held
// not ready. The entry state table is cleared by the same pass. A finished
// result sits in the output register until rsp.ready; a new command is
// taken only in a later cycle, so a stalled receiver stalls req and memory
// accesses never overlap. Memories: free FIFO, pending order, start times
// and entry state, each one write and one registered read per cycle.
module entry_pool_with_timed_queue_core (
   input logic  clock,
   input logic  reset,
   epq_req_if.sink   req,
   epq_rsp_if.source rsp
);
   import epq_pkg::*;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_RD    = 4'd2;
   localparam logic [3:0] S_DEC   = 4'd3;
   localparam logic [3:0] S_SRD   = 4'd4;   // read order slot
   localparam logic [3:0] S_SCMP  = 4'd5;   // compare/shift for unlink
   localparam logic [3:0] S_IRD   = 4'd6;   // insert: read order slot
   localparam logic [3:0] S_IRD2  = 4'd7;   // insert: read start of it
   localparam logic [3:0] S_ICMP  = 4'd8;
   localparam logic [3:0] S_MRD   = 4'd9;   // insert: move slot up
   localparam logic [3:0] S_MWR   = 4'd10;
   localparam logic [3:0] S_PEEK  = 4'd11;
   localparam logic [3:0] S_OUT   = 4'd12;
   localparam logic [3:0] S_FIN   = 4'd13;

   // memories
   logic [IDX_BITS-1:0]  free_mem [ENTRIES];
   logic [IDX_BITS-1:0]  ord_mem  [ENTRIES];
   logic [TIME_BITS-1:0] st_mem   [ENTRIES];
   logic [1:0]           es_mem   [ENTRIES];

   logic [3:0]          state_ff, state_in;
   req_type             cmd_ff, cmd_in;
   rsp_type             out_ff, out_in;
   logic                ovld_ff, ovld_in;
   logic [IDX_BITS-1:0] head_ff, head_in;
   logic [LVL_BITS-1:0] flvl_ff, flvl_in;
   logic [LVL_BITS-1:0] plvl_ff, plvl_in;
   logic [LVL_BITS-1:0] ptr_ff, ptr_in;
   logic                fnd_ff, fnd_in;    // unlink: match seen, shifting
   logic [IDX_BITS-1:0] qent_ff;           // queued entry while slot is in cmd.entry

   // memory ports
   logic                fr_re, fw_we, or_re, ow_we, sr_re, sw_we, er_re, ew_we;
   logic [IDX_BITS-1:0] fr_a, fw_a, or_a, ow_a, sr_a, sw_a, er_a, ew_a;
   logic [IDX_BITS-1:0] fw_d, ow_d;
   logic [TIME_BITS-1:0] sw_d;
   logic [1:0]          ew_d;
   logic [IDX_BITS-1:0] fr_q, or_q;
   logic [TIME_BITS-1:0] sr_q;
   logic [1:0]          er_q;

   always_ff @(posedge clock) begin
      if (fw_we) free_mem[fw_a] <= fw_d;
      if (fr_re) fr_q <= free_mem[fr_a];
      if (ow_we) ord_mem[ow_a] <= ow_d;
      if (or_re) or_q <= ord_mem[or_a];
      if (sw_we) st_mem[sw_a] <= sw_d;
      if (sr_re) sr_q <= st_mem[sr_a];
      if (ew_we) es_mem[ew_a] <= ew_d;
      if (er_re) er_q <= es_mem[er_a];
   end

   logic                 ent_ok;
   logic [IDX_BITS-1:0]  ent;
   logic [LVL_BITS:0]    tail_sum;
   assign ent_ok = ({1'b0, cmd_ff.entry} < 8'(ENTRIES));
   assign ent    = cmd_ff.entry[IDX_BITS-1:0];
   assign tail_sum = {2'b0, head_ff} + {1'b0, flvl_ff};

   // control sequencer
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      out_in   = out_ff;
      ovld_in  = ovld_ff;
      head_in  = head_ff;
      flvl_in  = flvl_ff;
      plvl_in  = plvl_ff;
      ptr_in   = ptr_ff;
      fnd_in   = fnd_ff;
      fr_re = 1'b0; fr_a = head_ff;
      fw_we = 1'b0; fw_a = '0; fw_d = '0;
      or_re = 1'b0; or_a = ptr_ff[IDX_BITS-1:0];
      ow_we = 1'b0; ow_a = '0; ow_d = '0;
      sr_re = 1'b0; sr_a = or_q;
      sw_we = 1'b0; sw_a = ent; sw_d = cmd_ff.begin_time;
      er_re = 1'b0; er_a = ent;
      ew_we = 1'b0; ew_a = ent; ew_d = ES_FREE;
      if (ovld_ff && rsp.ready) ovld_in = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            fw_we = 1'b1; fw_a = ptr_ff[IDX_BITS-1:0]; fw_d = ptr_ff[IDX_BITS-1:0];
            ew_we = 1'b1; ew_a = ptr_ff[IDX_BITS-1:0]; ew_d = ES_FREE;
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == LVL_BITS'(ENTRIES - 1)) begin
               ptr_in = '0;
               state_in = (ovld_ff && !rsp.ready) ? S_OUT : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req.valid && !ovld_ff) begin
               cmd_in = req.data;
               state_in = S_RD;
            end
         end
         S_RD: begin
            fr_re = 1'b1; er_re = 1'b1;
            or_re = 1'b1; or_a = '0;
            ptr_in = '0; fnd_in = 1'b0;
            state_in = S_DEC;
         end
         S_DEC: begin
            out_in = '0;
            out_in.status = STAT_OK;
            state_in = S_FIN;
            case (cmd_ff.command)
               CMD_ALLOC: begin
                  if (flvl_ff == '0) out_in.status = STAT_EMPTY;
                  else begin
                     out_in.result_entry = 7'(fr_q);
                     head_in = head_ff + 1'b1;
                     flvl_in = flvl_ff - 1'b1;
                     ew_we = 1'b1; ew_a = fr_q; ew_d = ES_ALLOC;
                  end
               end
               CMD_FREE: begin
                  if (!ent_ok || er_q == ES_FREE) out_in.status = STAT_BAD;
                  else begin
                     ew_we = 1'b1; ew_d = ES_FREE;
                     if (flvl_ff < LVL_BITS'(ENTRIES)) begin
                        fw_we = 1'b1; fw_a = tail_sum[IDX_BITS-1:0]; fw_d = ent;
                        flvl_in = flvl_ff + 1'b1;
                     end
                     if (er_q == ES_PEND) state_in = S_SRD;
                  end
               end
               CMD_QUEUE: begin
                  if (!ent_ok || er_q != ES_ALLOC) out_in.status = STAT_BAD;
                  else begin
                     ew_we = 1'b1; ew_d = ES_PEND;
                     state_in = S_IRD;
                  end
               end
               CMD_REMOVE: begin
                  if (!ent_ok || er_q != ES_PEND) out_in.status = STAT_BAD;
                  else begin
                     ew_we = 1'b1; ew_d = ES_ALLOC;
                     state_in = S_SRD;
                  end
               end
               CMD_PEEK: begin
                  if (plvl_ff == '0) out_in.status = STAT_EMPTY;
                  else begin
                     out_in.result_entry = 7'(or_q);
                     sr_re = 1'b1; sr_a = or_q;
                     state_in = S_PEEK;
                  end
               end
               CMD_RESET: begin
                  head_in = '0;
                  flvl_in = LVL_BITS'(ENTRIES);
                  plvl_in = '0;
                  ptr_in = '0;
               end
               default: out_in.status = STAT_BAD;
            endcase
         end
         S_PEEK: begin
            out_in.head_begin = 32'(sr_q);
            state_in = S_FIN;
         end
         // unlink: scan slots, after match copy slot i+1 into i
         S_SRD: begin
            or_re = 1'b1;
            state_in = S_SCMP;
         end
         S_SCMP: begin
            if (fnd_ff) begin
               ow_we = 1'b1; ow_a = IDX_BITS'(ptr_ff - 1'b1); ow_d = or_q;
            end
            if (!fnd_ff && or_q == ent) fnd_in = 1'b1;
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff + 1'b1 >= plvl_ff) begin
               plvl_in = plvl_ff - 1'b1;
               state_in = S_FIN;
            end else state_in = S_SRD;
         end
         // insert: find first slot whose start is not earlier
         S_IRD: begin
            if (ptr_ff >= plvl_ff) begin
               ow_we = 1'b1; ow_a = ptr_ff[IDX_BITS-1:0]; ow_d = ent;
               sw_we = 1'b1;
               plvl_in = plvl_ff + 1'b1;
               state_in = S_FIN;
            end else begin
               or_re = 1'b1;
               state_in = S_IRD2;
            end
         end
         S_IRD2: begin
            sr_re = 1'b1; sr_a = or_q;
            state_in = S_ICMP;
         end
         S_ICMP: begin
            if (sr_q < cmd_ff.begin_time) begin
               ptr_in = ptr_ff + 1'b1;
               state_in = S_IRD;
            end else begin
               fnd_in = 1'b0;
               cmd_in.entry = 7'(ptr_ff);      // insertion slot kept here
               ptr_in = plvl_ff;
               sw_we = 1'b1;
               state_in = S_MRD;
            end
         end
         S_MRD: begin
            if (ptr_ff == LVL_BITS'(cmd_ff.entry)) begin
               ow_we = 1'b1; ow_a = ptr_ff[IDX_BITS-1:0];
               ow_d = qent_ff;
               state_in = S_FIN;
               plvl_in = plvl_ff + 1'b1;
            end else begin
               or_re = 1'b1; or_a = IDX_BITS'(ptr_ff - 1'b1);
               state_in = S_MWR;
            end
         end
         S_MWR: begin
            ow_we = 1'b1; ow_a = ptr_ff[IDX_BITS-1:0]; ow_d = or_q;
            ptr_in = ptr_ff - 1'b1;
            state_in = S_MRD;
         end
         S_FIN: begin
            out_in.pending_nonempty = (plvl_ff != '0);
            out_in.free_count = 8'(flvl_ff);
            if (!ovld_ff || rsp.ready) begin
               ovld_in = 1'b1;
               state_in = (cmd_ff.command == CMD_RESET) ? S_CLEAR : S_IDLE;
            end
         end
         S_OUT: begin
            if (rsp.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DEC) qent_ff <= ent;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ovld_ff  <= 1'b0;
         head_ff  <= '0;
         flvl_ff  <= LVL_BITS'(ENTRIES);
         plvl_ff  <= '0;
         ptr_ff   <= '0;
         fnd_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ovld_ff  <= ovld_in;
         head_ff  <= head_in;
         flvl_ff  <= flvl_in;
         plvl_ff  <= plvl_in;
         ptr_ff   <= ptr_in;
         fnd_ff   <= fnd_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      out_ff <= out_in;
   end

   assign req.ready = (state_ff == S_IDLE) && !ovld_ff;
   assign rsp.valid = ovld_ff;
   assign rsp.data  = out_ff;
endmodule

// ----- rtl/epq_checker.sv -----
// Port-level checker for the entry pool core, bound to the top level.
// Depends on epq_pkg and entry_pool_with_timed_queue_core_macros.svh.
`include "entry_pool_with_timed_queue_core_macros.svh"
module epq_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input epq_pkg::rsp_type  rsp_data
);
   import epq_pkg::*;

   // a stalled result word holds
   `EPQ_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data), "rsp word changed while stalled")
   // one command in flight: no accept while a result waits
   `EPQ_ASSERT_IMP(a_one_flight, clock, reset, rsp_valid, !req_ready, "req accepted with result pending")
   // free count never exceeds the pool size
   `EPQ_ASSERT_IMP(a_fcount, clock, reset, rsp_valid, rsp_data.free_count <= 8'(ENTRIES), "free count too large")
   // status code in range
   `EPQ_ASSERT_IMP(a_status, clock, reset, rsp_valid, rsp_data.status != 2'd3, "bad status code")
endmodule

bind entry_pool_with_timed_queue_core epq_checker u_epq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_data  (rsp.data)
);
